@@ rtl/core/mbfs_pkg.sv @@
// Shared types and constants for the multichannel biquad frame-sum block.
package mbfs_pkg;

    localparam int COEF_W    = 18;           // Q3.14 coefficient width
    localparam int Y_W       = 32;           // full-precision output history width
    localparam int SUM_W     = 24;           // frame sum width
    localparam int SUMX_W    = SUM_W + 1;    // frame sum with one guard bit
    localparam int CH_W      = 8;            // channel field width
    localparam int CH_CODES  = 1 << CH_W;    // distinct channel codes
    localparam int PROD_W    = COEF_W + Y_W; // multiplier product width
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd4;

    // Coefficient reset values
    localparam logic signed [COEF_W-1:0] COEF_A0_RST = 18'sd2328;
    localparam logic signed [COEF_W-1:0] COEF_A1_RST = 18'sd4656;
    localparam logic signed [COEF_W-1:0] COEF_A2_RST = 18'sd2328;
    localparam logic signed [COEF_W-1:0] COEF_B1_RST = -18'sd11275;
    localparam logic signed [COEF_W-1:0] COEF_B2_RST = 18'sd4204;

    // Saturation limits of the output history
    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    // Saturation limits of the frame sum
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;  // register coef * operand
        logic acc_clr; // zero the accumulator
        logic acc_en;  // fold the registered product into the accumulator
        logic acc_sub; // feedback product: subtract, unscaled
    } mac_ctrl_t;

endpackage

@@ rtl/core/mbfs_mac.sv @@
// Shared multiply-accumulate unit: one registered product, one accumulator.
module mbfs_mac
    import mbfs_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int ACC_W     = 64
) (
    input  logic                     aclk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [Y_W-1:0]    operand,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    // Feed-forward terms carry FRAC_BITS fewer fraction bits than feedback
    // terms, so they are scaled up before they are added.
    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        acc_next = acc_reg;
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            if (ctrl.acc_sub) begin
                acc_next = acc_reg - prod_ext;
            end else begin
                acc_next = acc_reg + (prod_ext <<< FRAC_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(coef) * PROD_W'(operand);
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/core/multichannel_biquad_frame_sum.sv @@
// Top level: per-channel biquad low-pass filter with per-frame output sum.
//
// Each request carries one sample of one channel. The block runs a
// direct-form-I biquad per channel, y = a0*x + a1*x1 + a2*x2 - b1*y1 - b2*y2,
// with Q3.14 coefficients, and returns one result per request: the output
// truncated toward zero and saturated to SAMPLE_BITS, plus, on the request
// marked last in frame, the saturated 24-bit sum of the frame's outputs.
// Channel history (two inputs, two full-precision outputs) lives in one
// synchronous memory of CHANNELS entries; a channel code at or above
// CHANNELS folds onto entry code mod CHANNELS. Restart reads the history as
// zero for that request. One multiplier does the five products in turn,
// a drain step folds the last product into the accumulator, then FIN1
// rounds and saturates and FIN2 writes back. The memory read for the next
// request overlaps the write-back of the current one; a same-channel pair
// is forwarded. An input holding register takes the next request while one
// is in flight, and an output register holds the result until taken. After
// reset the history memory is zeroed, one entry a cycle; no request is
// accepted until that ends. Coefficients must be written by the user
// through cfg_wr_* only while the block is idle; the block itself does not
// enforce it.
module multichannel_biquad_frame_sum
    import mbfs_pkg::*;
#(
    parameter int CHANNELS       = 256,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_wr_index,
    input  logic [COEF_W-1:0]             cfg_wr_data,

    // Sample requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [CH_W-1:0]               s_channel,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  logic [31:0]                   s_frame_time,
    input  logic                          s_restart,
    input  logic                          s_last_in_frame,

    // Filtered results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CH_W-1:0]               m_out_channel,
    output logic signed [SAMPLE_BITS-1:0] m_filtered_value,
    output logic signed [SUM_W-1:0]       m_frame_sum,
    output logic [31:0]                   m_out_frame_time,
    output logic                          m_frame_done
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // a0*x + a1*x1 + a2*x2 scaled up by the fraction bits
    localparam int FF_W  = COEF_W + SAMPLE_BITS + 2 + COEF_FRAC_BITS;
    // b1*y1 + b2*y2
    localparam int FB_W  = COEF_W + Y_W + 1;
    localparam int ACC_W = ((FF_W > FB_W) ? FF_W : FB_W) + 1;
    localparam int YW_W  = ACC_W - COEF_FRAC_BITS;   // output before saturation
    localparam int Q_W   = Y_W + 1 - COEF_FRAC_BITS; // integer part after rounding
    localparam int QX_W  = (Q_W > SAMPLE_BITS) ? Q_W : SAMPLE_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    localparam logic signed [YW_W-1:0] Y_HI = YW_W'(Y_MAX);
    localparam logic signed [YW_W-1:0] Y_LO = YW_W'(Y_MIN);
    localparam logic signed [Y_W:0]    RND  =
        (Y_W+1)'((64'd1 << COEF_FRAC_BITS) - 64'd1);
    localparam logic signed [QX_W-1:0] S_HI =
        QX_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [QX_W-1:0] S_LO = ~S_HI;

    // MAC step numbers: step k multiplies term k and accumulates term k-1
    localparam logic [2:0] STEP_A0   = 3'd0;
    localparam logic [2:0] STEP_A1   = 3'd1;
    localparam logic [2:0] STEP_A2   = 3'd2;
    localparam logic [2:0] STEP_B1   = 3'd3;
    localparam logic [2:0] STEP_B2   = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    // Channel code to history entry (code mod CHANNELS), built at elaboration
    typedef logic [IDX_W-1:0] idx_tab_t [CH_CODES];

    function automatic idx_tab_t build_idx_tab();
        idx_tab_t t;
        for (int i = 0; i < CH_CODES; i++) begin
            t[i] = IDX_W'(i % CHANNELS);
        end
        return t;
    endfunction

    localparam idx_tab_t IDX_TABLE = build_idx_tab();

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [Y_W-1:0]         y1;
        logic signed [Y_W-1:0]         y2;
    } hist_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_FIN1,
        ST_FIN2
    } state_t;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t                        state_reg, state_next;
    logic [2:0]                    step_reg, step_next;
    logic [IDX_W-1:0]              clr_cnt_reg;

    logic signed [COEF_W-1:0]      coef_a0_reg, coef_a1_reg, coef_a2_reg;
    logic signed [COEF_W-1:0]      coef_b1_reg, coef_b2_reg;

    // Input holding register
    logic                          buf_full_reg;
    logic [CH_W-1:0]               buf_channel_reg;
    logic signed [SAMPLE_BITS-1:0] buf_sample_reg;
    logic [31:0]                   buf_time_reg;
    logic                          buf_restart_reg;
    logic                          buf_last_reg;

    // Request in flight
    logic [CH_W-1:0]               work_channel_reg;
    logic [IDX_W-1:0]              work_idx_reg;
    logic signed [SAMPLE_BITS-1:0] work_sample_reg;
    logic [31:0]                   work_time_reg;
    logic                          work_restart_reg;
    logic                          work_last_reg;

    // History memory and forwarding
    hist_t                         hist_mem [CHANNELS];
    hist_t                         rd_data_reg;
    logic                          fwd_reg;
    hist_t                         fwd_data_reg;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_wr_addr;
    hist_t                         mem_wr_data;
    hist_t                         hist_cur;
    hist_t                         hist_eff;
    hist_t                         wr_hist;

    logic                          s_accept;
    logic                          out_free;
    logic                          fin_go;
    logic                          load;
    logic [IDX_W-1:0]              buf_idx;

    // Datapath
    mac_ctrl_t                     mac_ctrl;
    logic signed [COEF_W-1:0]      mac_coef;
    logic signed [Y_W-1:0]         mac_operand;
    logic signed [ACC_W-1:0]       acc;

    logic signed [YW_W-1:0]        y_wide;
    logic signed [Y_W-1:0]         yfull_sat;
    logic signed [Y_W:0]           y_rnd;
    logic signed [Q_W-1:0]         q_int;
    logic signed [QX_W-1:0]        q_ext;
    logic signed [SAMPLE_BITS-1:0] yi_sat;
    logic signed [Y_W-1:0]         yfull_reg;
    logic signed [SAMPLE_BITS-1:0] yi_reg;

    logic signed [SUM_W-1:0]       running_sum_reg;
    logic signed [SUMX_W-1:0]      sum_wide;
    logic signed [SUM_W-1:0]       sum_sat;

    // Output register
    logic                          m_valid_reg;
    logic [CH_W-1:0]               m_channel_reg;
    logic signed [SAMPLE_BITS-1:0] m_value_reg;
    logic signed [SUM_W-1:0]       m_sum_reg;
    logic [31:0]                   m_time_reg;
    logic                          m_done_reg;

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    assign s_ready  = !buf_full_reg && (state_reg != ST_CLEAR);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_go   = (state_reg == ST_FIN2) && out_free;
    // Next request starts in the write-back cycle of the current one
    assign load     = buf_full_reg && ((state_reg == ST_IDLE) || fin_go);
    assign buf_idx  = IDX_TABLE[buf_channel_reg];

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (load) begin
                    state_next = ST_MAC;
                    step_next  = STEP_A0;
                end
            end
            ST_MAC: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FIN1;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_FIN1: begin
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (load) begin
                    state_next = ST_MAC;
                    step_next  = STEP_A0;
                end else if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // History memory: one write port (clear pass or write-back), one read
    // ------------------------------------------------------------------
    assign hist_cur = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign hist_eff = work_restart_reg ? '0 : hist_cur;

    always_comb begin
        wr_hist.x1 = work_sample_reg;
        wr_hist.x2 = hist_eff.x1;
        wr_hist.y1 = yfull_reg;
        wr_hist.y2 = hist_eff.y1;
    end

    assign mem_we      = (state_reg == ST_CLEAR) || fin_go;
    assign mem_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : work_idx_reg;
    assign mem_wr_data = (state_reg == ST_CLEAR) ? '0 : wr_hist;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rd_data_reg <= hist_mem[buf_idx];
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate: term order a0*x, a1*x1, a2*x2, b1*y1, b2*y2
    // ------------------------------------------------------------------
    always_comb begin
        mac_ctrl.mul_en  = (state_reg == ST_MAC) && (step_reg <= STEP_B2);
        mac_ctrl.acc_clr = load;
        mac_ctrl.acc_en  = (state_reg == ST_MAC) && (step_reg != STEP_A0);
        mac_ctrl.acc_sub = (step_reg > STEP_B1);  // products from b1, b2
    end

    always_comb begin
        case (step_reg)
            STEP_A0: begin
                mac_coef    = coef_a0_reg;
                mac_operand = Y_W'(work_sample_reg);
            end
            STEP_A1: begin
                mac_coef    = coef_a1_reg;
                mac_operand = Y_W'(hist_eff.x1);
            end
            STEP_A2: begin
                mac_coef    = coef_a2_reg;
                mac_operand = Y_W'(hist_eff.x2);
            end
            STEP_B1: begin
                mac_coef    = coef_b1_reg;
                mac_operand = hist_eff.y1;
            end
            STEP_B2: begin
                mac_coef    = coef_b2_reg;
                mac_operand = hist_eff.y2;
            end
            default: begin
                mac_coef    = '0;
                mac_operand = '0;
            end
        endcase
    end

    mbfs_mac #(
        .FRAC_BITS (COEF_FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .acc     (acc)
    );

    // ------------------------------------------------------------------
    // FIN1: floor to full-precision output, saturate, round toward zero
    // ------------------------------------------------------------------
    assign y_wide = acc[ACC_W-1:COEF_FRAC_BITS];

    always_comb begin
        if (y_wide > Y_HI) begin
            yfull_sat = Y_MAX;
        end else if (y_wide < Y_LO) begin
            yfull_sat = Y_MIN;
        end else begin
            yfull_sat = y_wide[Y_W-1:0];
        end
        // negative values get a bias so the shift rounds toward zero
        y_rnd = (Y_W+1)'(yfull_sat) + (yfull_sat[Y_W-1] ? RND : '0);
        q_int = y_rnd[Y_W:COEF_FRAC_BITS];
        q_ext = QX_W'(q_int);
        if (q_ext > S_HI) begin
            yi_sat = S_HI[SAMPLE_BITS-1:0];
        end else if (q_ext < S_LO) begin
            yi_sat = S_LO[SAMPLE_BITS-1:0];
        end else begin
            yi_sat = q_ext[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // FIN2: frame sum with saturation
    // ------------------------------------------------------------------
    always_comb begin
        sum_wide = SUMX_W'(running_sum_reg) + SUMX_W'(yi_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            step_reg        <= STEP_A0;
            clr_cnt_reg     <= '0;
            buf_full_reg    <= 1'b0;
            fwd_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
            running_sum_reg <= '0;
            coef_a0_reg     <= COEF_A0_RST;
            coef_a1_reg     <= COEF_A1_RST;
            coef_a2_reg     <= COEF_A2_RST;
            coef_b1_reg     <= COEF_B1_RST;
            coef_b2_reg     <= COEF_B2_RST;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end

            if (s_accept) begin
                buf_full_reg <= 1'b1;
            end else if (load) begin
                buf_full_reg <= 1'b0;
            end

            // same channel back to back: memory read sees the old entry
            if (load) begin
                fwd_reg <= fin_go && (buf_idx == work_idx_reg);
            end

            if (fin_go) begin
                m_valid_reg     <= 1'b1;
                running_sum_reg <= work_last_reg ? '0 : sum_sat;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_COEF_A0: coef_a0_reg <= cfg_wr_data;
                    REG_COEF_A1: coef_a1_reg <= cfg_wr_data;
                    REG_COEF_A2: coef_a2_reg <= cfg_wr_data;
                    REG_COEF_B1: coef_b1_reg <= cfg_wr_data;
                    REG_COEF_B2: coef_b2_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            buf_channel_reg <= s_channel;
            buf_sample_reg  <= s_sample_value;
            buf_time_reg    <= s_frame_time;
            buf_restart_reg <= s_restart;
            buf_last_reg    <= s_last_in_frame;
        end

        if (load) begin
            work_channel_reg <= buf_channel_reg;
            work_idx_reg     <= buf_idx;
            work_sample_reg  <= buf_sample_reg;
            work_time_reg    <= buf_time_reg;
            work_restart_reg <= buf_restart_reg;
            work_last_reg    <= buf_last_reg;
            fwd_data_reg     <= wr_hist;
        end

        if (state_reg == ST_FIN1) begin
            yfull_reg <= yfull_sat;
            yi_reg    <= yi_sat;
        end

        if (fin_go) begin
            m_channel_reg <= work_channel_reg;
            m_value_reg   <= yi_reg;
            m_sum_reg     <= work_last_reg ? sum_sat : '0;
            m_time_reg    <= work_time_reg;
            m_done_reg    <= work_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_channel    = m_channel_reg;
    assign m_filtered_value = m_value_reg;
    assign m_frame_sum      = m_sum_reg;
    assign m_out_frame_time = m_time_reg;
    assign m_frame_done     = m_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_fin_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> m_valid)
        else $error("write-back without result");

    a_sum_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_done) |-> (m_frame_sum == '0))
        else $error("frame sum shown on a non-final result");

    a_load_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> ((state_reg == ST_MAC) && (step_reg == STEP_A0) && !buf_full_reg))
        else $error("request start did not enter MAC sequence");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (step_reg <= STEP_LAST))
        else $error("MAC step out of range");

    a_fwd_from_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fwd_reg) |-> $past(fin_go))
        else $error("forwarding set without a write-back");
`endif

endmodule

@@ verif/mbfs_checker.sv @@
`timescale 1ns / 1ps
// Checker for the biquad frame-sum block: predicts each result and compares it on the way out.
module mbfs_checker
    import mbfs_pkg::*;
#(
    parameter int CHANNELS       = 256,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_wr_index,
    input  logic [COEF_W-1:0]             cfg_wr_data,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [CH_W-1:0]               s_channel,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  logic [31:0]                   s_frame_time,
    input  logic                          s_restart,
    input  logic                          s_last_in_frame,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [CH_W-1:0]               m_out_channel,
    input  logic signed [SAMPLE_BITS-1:0] m_filtered_value,
    input  logic signed [SUM_W-1:0]       m_frame_sum,
    input  logic [31:0]                   m_out_frame_time,
    input  logic                          m_frame_done,

    output int                            errors,
    output int                            pending
);

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [CH_W-1:0]               channel;
        logic signed [SAMPLE_BITS-1:0] value;
        logic signed [SUM_W-1:0]       sum;
        logic [31:0]                   ftime;
        logic                          done;
    } filter_result_t;

    // Coefficient copy
    logic signed [COEF_W-1:0] c_a0, c_a1, c_a2, c_b1, c_b2;

    // Per-channel history and the open frame's partial sum
    logic signed [SAMPLE_BITS-1:0] x_d1 [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] x_d2 [CHANNELS];
    logic signed [Y_W-1:0]         y_d1 [CHANNELS];
    logic signed [Y_W-1:0]         y_d2 [CHANNELS];
    logic signed [SUM_W-1:0]       frame_acc;

    filter_result_t filtered_q [$];
    int             results_seen;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One filter step: returns the result and advances the channel's history.
    function automatic filter_result_t biquad_step(input logic [CH_W-1:0] ch,
                                                   input logic signed [SAMPLE_BITS-1:0] x,
                                                   input logic [31:0] ftime,
                                                   input logic restart,
                                                   input logic last);
        int             slot;
        longint         x1, x2, y1, y2, ff, fb, y_full, y_int, total, s_hi;
        filter_result_t r;
        slot = int'(ch) % CHANNELS;
        s_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1);
        x1 = restart ? '0 : longint'(x_d1[slot]);
        x2 = restart ? '0 : longint'(x_d2[slot]);
        y1 = restart ? '0 : longint'(y_d1[slot]);
        y2 = restart ? '0 : longint'(y_d2[slot]);
        ff = longint'(c_a0) * longint'(x) + longint'(c_a1) * x1 + longint'(c_a2) * x2;
        fb = longint'(c_b1) * y1 + longint'(c_b2) * y2;
        // floor division by the Q scale is an arithmetic shift
        y_full = ((ff <<< COEF_FRAC_BITS) - fb) >>> COEF_FRAC_BITS;
        y_full = clamp(y_full, longint'(Y_MIN), longint'(Y_MAX));
        // signed division truncates toward zero
        y_int = clamp(y_full / (longint'(1) <<< COEF_FRAC_BITS), -s_hi - longint'(1), s_hi);

        x_d2[slot] = x1[SAMPLE_BITS-1:0];
        x_d1[slot] = x;
        y_d2[slot] = y1[Y_W-1:0];
        y_d1[slot] = y_full[Y_W-1:0];

        total = clamp(longint'(frame_acc) + y_int, longint'(SUM_MIN), longint'(SUM_MAX));
        r.channel = ch;
        r.value   = y_int[SAMPLE_BITS-1:0];
        r.ftime   = ftime;
        r.done    = last;
        if (last) begin
            r.sum     = total[SUM_W-1:0];
            frame_acc = '0;
        end else begin
            r.sum     = '0;
            frame_acc = total[SUM_W-1:0];
        end
        return r;
    endfunction

    // Prints one line (up to a cap) and counts.
    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (errors < PRINT_CAP) begin
            $display("mismatch: result %0d %s: got %0d, expected %0d",
                     results_seen, field, got, want);
        end
        errors++;
    endtask

    always @(posedge aclk) begin
        filter_result_t want;
        if (!aresetn) begin
            c_a0 = COEF_A0_RST;
            c_a1 = COEF_A1_RST;
            c_a2 = COEF_A2_RST;
            c_b1 = COEF_B1_RST;
            c_b2 = COEF_B2_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                x_d1[i] = '0;
                x_d2[i] = '0;
                y_d1[i] = '0;
                y_d2[i] = '0;
            end
            frame_acc = '0;
            filtered_q.delete();
            errors       = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_COEF_A0: c_a0 = cfg_wr_data;
                    REG_COEF_A1: c_a1 = cfg_wr_data;
                    REG_COEF_A2: c_a2 = cfg_wr_data;
                    REG_COEF_B1: c_b1 = cfg_wr_data;
                    REG_COEF_B2: c_b2 = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("result with no request, channel",
                                    longint'(m_out_channel), longint'(-1));
                end else begin
                    want = filtered_q.pop_front();
                    if (m_out_channel !== want.channel)
                        report_mismatch("out_channel", longint'(m_out_channel),
                                        longint'(want.channel));
                    if (m_filtered_value !== want.value)
                        report_mismatch("filtered_value", longint'(m_filtered_value),
                                        longint'(want.value));
                    if (m_frame_sum !== want.sum)
                        report_mismatch("frame_sum", longint'(m_frame_sum),
                                        longint'(want.sum));
                    if (m_out_frame_time !== want.ftime)
                        report_mismatch("out_frame_time", longint'(m_out_frame_time),
                                        longint'(want.ftime));
                    if (m_frame_done !== want.done)
                        report_mismatch("frame_done", longint'(m_frame_done),
                                        longint'(want.done));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                filtered_q.push_back(biquad_step(s_channel, s_sample_value, s_frame_time,
                                                 s_restart, s_last_in_frame));
            end
        end
        pending <= filtered_q.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, coefficient programming, sample stimulus and verdict.
module testbench
    import mbfs_pkg::*;
();

    localparam int CHANNELS       = 256;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 14;

    // Watchdog: longest honest quiet stretch is the post-reset clear or one
    // request's gap + pipe latency + result stall; this is far above both.
    localparam int IDLE_LIMIT   = 2000;
    // Extra quiet cycles after the last result before a coefficient write or the end
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_IDLE     = 19;

    localparam logic signed [COEF_W-1:0] COEF_POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_NEG_MAX = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] COEF_UNITY   = COEF_W'(1 << COEF_FRAC_BITS);
    localparam logic signed [COEF_W-1:0] COEF_ZERO    = '0;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_wr_index;
    logic [COEF_W-1:0]             cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [CH_W-1:0]               s_channel;
    logic signed [SAMPLE_BITS-1:0] s_sample_value;
    logic [31:0]                   s_frame_time;
    logic                          s_restart;
    logic                          s_last_in_frame;
    logic                          m_valid;
    logic                          m_ready;
    logic [CH_W-1:0]               m_out_channel;
    logic signed [SAMPLE_BITS-1:0] m_filtered_value;
    logic signed [SUM_W-1:0]       m_frame_sum;
    logic [31:0]                   m_out_frame_time;
    logic                          m_frame_done;

    int errors;
    int pending;
    int requests_sent;
    int frames_closed;
    int results_taken;
    int coef_sets;
    int idle_cycles;

    // Idle knobs, flipped per frame so that runs with and without gaps both occur
    bit tx_gaps_on;
    bit rx_stalls_on;

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    multichannel_biquad_frame_sum #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample_value   (s_sample_value),
        .s_frame_time     (s_frame_time),
        .s_restart        (s_restart),
        .s_last_in_frame  (s_last_in_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_channel    (m_out_channel),
        .m_filtered_value (m_filtered_value),
        .m_frame_sum      (m_frame_sum),
        .m_out_frame_time (m_out_frame_time),
        .m_frame_done     (m_frame_done)
    );

    // Watches both channels, predicts and compares; hands back fail and backlog counts
    mbfs_checker #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample_value   (s_sample_value),
        .s_frame_time     (s_frame_time),
        .s_restart        (s_restart),
        .s_last_in_frame  (s_last_in_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_channel    (m_out_channel),
        .m_filtered_value (m_filtered_value),
        .m_frame_sum      (m_frame_sum),
        .m_out_frame_time (m_out_frame_time),
        .m_frame_done     (m_frame_done),
        .errors           (errors),
        .pending          (pending)
    );

    // Watchdog: counts cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (m_valid && m_ready) begin
            results_taken <= results_taken + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: a random stall before each result, then ready held until it is taken
    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Sample mix: rails, small values around zero, and full-range noise
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SAMPLE_BITS'(int'($urandom_range(0, 127)) - 64);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // One request. Valid is only dropped when a gap is drawn, so back-to-back
    // requests never lower and raise valid in the same step.
    task automatic push_sample(input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_BITS-1:0] smp,
                               input logic [31:0] stamp,
                               input bit rst,
                               input bit last);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_channel       <= ch;
        s_sample_value  <= smp;
        s_frame_time    <= stamp;
        s_restart       <= rst;
        s_last_in_frame <= last;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (last) frames_closed++;
    endtask

    // A frame in row order from a random first channel; channel codes wrap at the top.
    // Without the marker the sum keeps running into whatever comes next.
    task automatic send_frame(input int len, input bit marked, input bit hold_level,
                              input logic signed [SAMPLE_BITS-1:0] level);
        logic [CH_W-1:0] ch;
        logic [31:0]     stamp;
        bit              all_restart;
        ch          = CH_W'($urandom_range(0, CH_CODES - 1));
        stamp       = $urandom;
        all_restart = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
            push_sample(ch, hold_level ? level : rand_sample(), stamp,
                        all_restart || ($urandom_range(0, 15) == 0),
                        marked && (i == len - 1));
            ch = ch + CH_W'(1);
        end
    endtask

    // Unordered requests: random channel, restart and last marker
    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++) begin
            push_sample(CH_W'($urandom_range(0, CH_CODES - 1)), rand_sample(), $urandom,
                        $urandom_range(0, 1) != 0, $urandom_range(0, 3) == 0);
        end
    endtask

    // Mostly well-formed short frames, some noise and some frames missing the marker
    task automatic run_random(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(1, 24);
                send_frame(len, 1'b1, 1'b0, '0);
            end else if (pick < 9) begin
                len = $urandom_range(1, 8);
                send_noise(len);
            end else begin
                len = $urandom_range(2, 24);
                send_frame(len, 1'b0, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    // Coefficients only change with the pipe empty: wait out the backlog, then a margin
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all five coefficients on consecutive cycles
    task automatic program_coefs(input logic signed [COEF_W-1:0] a0, a1, a2, b1, b2);
        logic signed [COEF_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]     regs [5];
        vals = '{a0, a1, a2, b1, b2};
        regs = '{REG_COEF_A0, REG_COEF_A1, REG_COEF_A2, REG_COEF_B1, REG_COEF_B2};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= regs[i];
            cfg_wr_data  <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        coef_sets++;
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_index    <= '0;
        cfg_wr_data     <= '0;
        s_valid         <= 1'b0;
        s_channel       <= '0;
        s_sample_value  <= '0;
        s_frame_time    <= '0;
        s_restart       <= 1'b0;
        s_last_in_frame <= 1'b0;
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b1;
        coef_sets       = 1;   // reset defaults count as the first setting
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset coefficients. The block clears its history memory first;
        // the handshake simply waits for that.
        // Rails on channel 0, back to back (same-channel forwarding), time stamp extremes
        push_sample(8'd0,   SMP_MAX, 32'h0000_0000, 1'b1, 1'b0);
        push_sample(8'd0,   SMP_MAX, 32'h0000_0000, 1'b0, 1'b0);
        push_sample(8'd0,   SMP_MIN, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Top channel code, negative rail
        push_sample(8'd255, SMP_MIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_sample(8'd255, SMP_MIN, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_sample(8'd1,   16'sd0,  32'h5A5A_A5A5, 1'b0, 1'b0);
        // Restart with live history behind it
        push_sample(8'd0,   16'sd100, 32'hA5A5_5A5A, 1'b1, 1'b0);
        push_sample(8'd0,   -16'sd1,  32'hA5A5_5A5A, 1'b0, 1'b0);
        // Close the frame; then single-request frames
        push_sample(8'd255, SMP_MAX, 32'h8000_0001, 1'b0, 1'b1);
        push_sample(8'd7,   SMP_MIN, 32'h7FFF_FFFE, 1'b0, 1'b1);
        push_sample(8'd7,   16'sd1,  32'h7FFF_FFFE, 1'b1, 1'b1);
        // With idle gaps now: a frame across the channel-code wrap
        tx_gaps_on = 1'b1;
        push_sample(8'd254, SMP_MAX, 32'h1234_5678, 1'b0, 1'b0);
        push_sample(8'd255, SMP_MIN, 32'h1234_5678, 1'b0, 1'b0);
        push_sample(8'd0,   SMP_MAX, 32'h1234_5678, 1'b0, 1'b0);
        push_sample(8'd1,   SMP_MIN, 32'h1234_5678, 1'b0, 1'b0);
        push_sample(8'd2,   SMP_MAX, 32'h1234_5678, 1'b0, 1'b0);
        push_sample(8'd3,   16'sd0,  32'h1234_5678, 1'b0, 1'b1);
        // Same channel three times, restart only in the middle
        push_sample(8'd5,   16'sd12345,  32'hDEAD_0000, 1'b0, 1'b0);
        push_sample(8'd5,   -16'sd12345, 32'hDEAD_0000, 1'b1, 1'b0);
        push_sample(8'd5,   16'sd321,    32'hDEAD_0000, 1'b0, 1'b1);
        // Two markerless requests: their sum carries into the first random frame
        push_sample(8'd9,   SMP_MAX, 32'h0F0F_0F0F, 1'b0, 1'b0);
        push_sample(8'd10,  SMP_MAX, 32'h0F0F_0F0F, 1'b0, 1'b0);

        run_random(80);
        settle();

        // Positive rail coefficients: heavy saturation of history and output
        program_coefs(COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX);
        run_random(50);
        settle();

        // Negative rail coefficients
        program_coefs(COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX);
        run_random(50);
        settle();

        // Unity pass-through: 258 rail samples in one frame push the sum past
        // both ends of its range
        program_coefs(COEF_UNITY, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_frame(258, 1'b1, 1'b1, SMP_MAX);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_frame(258, 1'b1, 1'b1, SMP_MIN);
        run_random(30);
        settle();

        // Full-range random coefficient sets
        repeat (2) begin
            program_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                          COEF_W'($urandom), COEF_W'($urandom));
            run_random(50);
            settle();
        end

        // Back to the low-pass defaults, this time through the write port
        program_coefs(COEF_A0_RST, COEF_A1_RST, COEF_A2_RST, COEF_B1_RST, COEF_B2_RST);
        run_random(50);
        settle();

        $display("summary: %0d requests, %0d closed frames, %0d results checked",
                 requests_sent, frames_closed, results_taken);
        $display("summary: %0d coefficient sets (rails, unity, random, defaults), %0s",
                 coef_sets, "sum saturated both ways, restarts, channel wrap, gaps and stalls");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
